// File: rtl/rpfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfr_pkg
// Shared types and codes for the pump bus frame recognizer.
// ----------------------------------------------------------------------------
package rpfr_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_A5_HDR  = 3'd1,
    PH_A5_BODY = 3'd2,
    PH_A5_CK1  = 3'd3,
    PH_A5_CK2  = 3'd4,
    PH_DLE_02  = 3'd5,
    PH_DLE_90  = 3'd6
  } phase_t;

  // frame kinds
  localparam logic [1:0] KIND_A5  = 2'd0;
  localparam logic [1:0] KIND_DLE = 2'd1;
  localparam logic [1:0] KIND_LOG = 2'd2;

  // frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CKS = 2'd1;
  localparam logic [1:0] ST_NO_TERM = 2'd2;

  // framing bytes
  localparam logic [7:0] A5_START  = 8'hA5;
  localparam logic [7:0] DLE       = 8'h10;
  localparam logic [7:0] DLE_STX   = 8'h02;
  localparam logic [7:0] DLE_ETX   = 8'h03;
  localparam logic [7:0] LOG_STX   = 8'h90;
  localparam logic [7:0] LOG_ETX   = 8'h91;
  localparam logic [7:0] DLE_SEED  = 8'h12;
  localparam int         A5_HDR_BYTES = 6;

  // one frame summary
  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [1:0]  frame_status;
    logic [7:0]  dest_addr;
    logic [7:0]  src_addr;
    logic [7:0]  command_code;
    logic [7:0]  payload_len;
    logic [8:0]  frame_bytes;
    logic        filtered_out;
    logic [15:0] rx_checksum;
  } frame_result_t;

endpackage

// File: rtl/rpfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfr_parser
// Byte-wide frame parser: parse state registers and the one-byte step logic.
// ----------------------------------------------------------------------------
module rpfr_parser #(
  parameter int DLE_MAX_BYTES = 64,
  parameter int LOG_MIN_BYTES = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             addr_filter,
  output logic                   emit,
  output rpfr_pkg::frame_result_t result
);
  import rpfr_pkg::*;

  localparam logic [8:0] DLE_MAX = 9'(DLE_MAX_BYTES);
  localparam logic [8:0] LOG_MIN = 9'(LOG_MIN_BYTES);

  phase_t      phase, phase_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  sum_before_last, sum_before_last_next;
  logic [7:0]  last_byte, last_byte_next;
  logic        escape_seen, escape_seen_next;
  logic [7:0]  header_dest, header_dest_next;
  logic [7:0]  header_src, header_src_next;
  logic [7:0]  header_cmd, header_cmd_next;
  logic [7:0]  header_len, header_len_next;
  logic [7:0]  cks_high, cks_high_next;

  // step logic for one byte
  always_comb begin
    logic [8:0]  cnt_inc;
    logic [9:0]  body_end;
    logic [8:0]  msz;
    logic [7:0]  term;
    logic [1:0]  kind;
    logic        is_log;
    logic        filt_a5;
    logic        filt_dle;
    logic [15:0] cks;

    phase_next           = phase;
    byte_count_next      = byte_count;
    running_sum_next     = running_sum;
    sum_before_last_next = sum_before_last;
    last_byte_next       = last_byte;
    escape_seen_next     = escape_seen;
    header_dest_next     = header_dest;
    header_src_next      = header_src;
    header_cmd_next      = header_cmd;
    header_len_next      = header_len;
    cks_high_next        = cks_high;
    emit                 = 1'b0;
    result               = '0;

    cnt_inc  = byte_count + 9'd1;
    body_end = 10'(A5_HDR_BYTES) + {2'b00, header_len};
    msz      = cnt_inc;
    is_log   = (phase == PH_DLE_90);
    term     = is_log ? LOG_ETX : DLE_ETX;
    kind     = is_log ? KIND_LOG : KIND_DLE;
    filt_a5  = (addr_filter != 8'd0) && (header_dest != addr_filter) &&
               (header_src != addr_filter);
    filt_dle = (addr_filter != 8'd0);
    cks      = {cks_high, rx_byte};

    case (phase)
      // look for a frame start
      PH_HUNT: begin
        if (rx_byte == A5_START) begin
          phase_next       = PH_A5_HDR;
          byte_count_next  = 9'd1;
          running_sum_next = {8'd0, A5_START};
          escape_seen_next = 1'b0;
          header_dest_next = '0;
          header_src_next  = '0;
          header_cmd_next  = '0;
          header_len_next  = '0;
          cks_high_next    = '0;
        end else if (escape_seen && (rx_byte inside {DLE_STX, LOG_STX})) begin
          phase_next           = (rx_byte == DLE_STX) ? PH_DLE_02 : PH_DLE_90;
          byte_count_next      = 9'd2;
          last_byte_next       = rx_byte;
          cks_high_next        = DLE;
          sum_before_last_next = DLE_SEED;
          escape_seen_next     = 1'b0;
        end else begin
          escape_seen_next = (rx_byte == DLE);
        end
      end

      // a5 header bytes
      PH_A5_HDR: begin
        running_sum_next = running_sum + {8'd0, rx_byte};
        case (byte_count)
          9'd2:    header_dest_next = rx_byte;
          9'd3:    header_src_next  = rx_byte;
          9'd4:    header_cmd_next  = rx_byte;
          9'd5:    header_len_next  = rx_byte;
          default: ;
        endcase
        byte_count_next = cnt_inc;
        if (cnt_inc >= 9'(A5_HDR_BYTES))
          phase_next = (header_len_next != 8'd0) ? PH_A5_BODY : PH_A5_CK1;
      end

      // a5 payload
      PH_A5_BODY: begin
        running_sum_next = running_sum + {8'd0, rx_byte};
        byte_count_next  = cnt_inc;
        if ({1'b0, cnt_inc} >= body_end)
          phase_next = PH_A5_CK1;
      end

      // a5 checksum high byte
      PH_A5_CK1: begin
        cks_high_next   = rx_byte;
        byte_count_next = cnt_inc;
        phase_next      = PH_A5_CK2;
      end

      // a5 checksum low byte, frame done
      PH_A5_CK2: begin
        emit                = 1'b1;
        result.frame_kind   = KIND_A5;
        result.frame_status = (running_sum == cks) ? ST_OK : ST_BAD_CKS;
        result.dest_addr    = header_dest;
        result.src_addr     = header_src;
        result.command_code = header_cmd;
        result.payload_len  = header_len;
        result.frame_bytes  = cnt_inc;
        result.filtered_out = filt_a5;
        result.rx_checksum  = cks;
        phase_next          = PH_HUNT;
        byte_count_next     = '0;
        escape_seen_next    = 1'b0;
      end

      // dle body, watch for terminator and length limit
      PH_DLE_02, PH_DLE_90: begin
        result.frame_kind   = kind;
        result.filtered_out = filt_dle;
        if ((byte_count >= 9'd3) && (last_byte == DLE) && (rx_byte == term)) begin
          emit               = 1'b1;
          result.frame_bytes = msz;
          if (is_log && (msz < LOG_MIN)) begin
            result.frame_status = ST_NO_TERM;
          end else begin
            result.frame_status = (sum_before_last == cks_high) ? ST_OK : ST_BAD_CKS;
            result.payload_len  = (msz >= 9'd5) ? 8'(msz - 9'd5) : 8'd0;
            result.rx_checksum  = {8'd0, cks_high};
          end
          phase_next       = PH_HUNT;
          byte_count_next  = '0;
          escape_seen_next = 1'b0;
        end else begin
          if (byte_count >= 9'd4)
            sum_before_last_next = sum_before_last + cks_high;
          cks_high_next   = last_byte;
          last_byte_next  = rx_byte;
          byte_count_next = cnt_inc;
          if (cnt_inc >= DLE_MAX) begin
            emit                = 1'b1;
            result.frame_status = ST_NO_TERM;
            result.frame_bytes  = DLE_MAX;
            phase_next          = PH_HUNT;
            byte_count_next     = '0;
            escape_seen_next    = 1'b0;
          end
        end
      end

      default: begin
        phase_next       = PH_HUNT;
        byte_count_next  = '0;
        escape_seen_next = 1'b0;
      end
    endcase
  end

  // parse state, advanced once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      byte_count      <= '0;
      running_sum     <= '0;
      sum_before_last <= '0;
      last_byte       <= '0;
      escape_seen     <= 1'b0;
      header_dest     <= '0;
      header_src      <= '0;
      header_cmd      <= '0;
      header_len      <= '0;
      cks_high        <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      running_sum     <= running_sum_next;
      sum_before_last <= sum_before_last_next;
      last_byte       <= last_byte_next;
      escape_seen     <= escape_seen_next;
      header_dest     <= header_dest_next;
      header_src      <= header_src_next;
      header_cmd      <= header_cmd_next;
      header_len      <= header_len_next;
      cks_high        <= cks_high_next;
    end
  end

endmodule

// File: rtl/rpfr_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfr_out_reg
// Result register with valid/ready; frees itself in the cycle it is taken.
// ----------------------------------------------------------------------------
module rpfr_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    emit,
  input  rpfr_pkg::frame_result_t result_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rpfr_pkg::frame_result_t result_out
);
  import rpfr_pkg::*;

  logic accept;

  // room when empty or being drained this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result_out <= result_in;
    end
  end

endmodule

// File: rtl/rs485_pump_frame_recognizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_pump_frame_recognizer
// Finds A5 and DLE framed messages in a pump bus byte stream.
// ----------------------------------------------------------------------------
// Takes one received bus byte per beat and hands out one summary per frame
// (kind, checksum status, header fields, sizes, address-filter mark). A byte
// is accepted every cycle while the result register is empty or being taken;
// the frame summary is registered and appears in the cycle after the frame's
// last byte is accepted. The rate is set by the combinational parser step
// feeding one output register. The filter register is written over the cfg
// beat channel, which is always ready.
module rs485_pump_frame_recognizer #(
  parameter int DLE_MAX_BYTES = 64,
  parameter int LOG_MIN_BYTES = 13
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] frame_kind,
  output logic [1:0] frame_status,
  output logic [7:0] dest_addr,
  output logic [7:0] src_addr,
  output logic [7:0] command_code,
  output logic [7:0] payload_len,
  output logic [8:0] frame_bytes,
  output logic       filtered_out,
  output logic [15:0] rx_checksum
);
  import rpfr_pkg::*;

  logic          addr_filter;
  logic [7:0]    addr_filter_reg;
  logic          emit;
  frame_result_t step_result;
  frame_result_t held_result;

  // filter register
  assign cfg_ready   = 1'b1;
  assign addr_filter = (addr_filter_reg != 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_filter_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      addr_filter_reg <= cfg_data;
    end
  end

  // parser
  rpfr_parser #(
    .DLE_MAX_BYTES (DLE_MAX_BYTES),
    .LOG_MIN_BYTES (LOG_MIN_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_valid && in_ready),
    .rx_byte     (rx_byte),
    .addr_filter (addr_filter_reg),
    .emit        (emit),
    .result      (step_result)
  );

  // result register
  rpfr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .emit       (emit),
    .result_in  (step_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (held_result)
  );

  // result fields; dle frames carry the mark whenever the filter is set
  assign frame_kind   = held_result.frame_kind;
  assign frame_status = held_result.frame_status;
  assign dest_addr    = held_result.dest_addr;
  assign src_addr     = held_result.src_addr;
  assign command_code = held_result.command_code;
  assign payload_len  = held_result.payload_len;
  assign frame_bytes  = held_result.frame_bytes;
  assign filtered_out = held_result.filtered_out && (addr_filter ||
                        (held_result.frame_kind == KIND_A5));
  assign rx_checksum  = held_result.rx_checksum;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pump bus frame recognizer.
// ----------------------------------------------------------------------------
// Streams bus bytes into the recognizer over its valid/ready input channel.
// A short table of hand-built frames comes first (escape handling, DLE frames
// with good and bad checksums, a short log frame, an A5 frame at the field
// extremes). Then well-formed A5, DLE and log frames with random content are
// mixed with runaway DLE frames, bad checksums and line noise. An in-bench
// parser model predicts summaries the table does not type in, and each result
// beat is compared field by field. The address filter is rewritten between
// phases while the block is idle. Both channels get random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
  import rpfr_pkg::*;

  localparam int DLE_LIMIT    = 64;
  localparam int LOG_MIN      = 13;
  localparam int SETTLE       = 4;
  localparam int PHASE_BYTES  = 325;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DIR_ROWS     = 25;

  localparam frame_result_t NO_FRAME = '0;

  // one directed byte, with its typed summary where it ends a frame
  typedef struct packed {
    logic [7:0]    rx;
    logic          has_want;
    frame_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  frame_kind;
  logic [1:0]  frame_status;
  logic [7:0]  dest_addr;
  logic [7:0]  src_addr;
  logic [7:0]  command_code;
  logic [7:0]  payload_len;
  logic [8:0]  frame_bytes;
  logic        filtered_out;
  logic [15:0] rx_checksum;

  // parser model state
  phase_t      ph;
  logic [8:0]  cnt;
  logic [15:0] a5_sum;
  logic [7:0]  dle_sum;
  logic [7:0]  prev_byte;
  logic [7:0]  chk_hi;
  logic [7:0]  hd_dest;
  logic [7:0]  hd_src;
  logic [7:0]  hd_cmd;
  logic [7:0]  hd_len;
  logic        esc;
  logic [7:0]  filt_reg;

  frame_result_t expected_frames [$];
  logic          beat_typed;
  frame_result_t beat_want;
  bit            sender_burst;
  dir_row_t      dir_rows [DIR_ROWS];

  int fail_count;
  int bytes_in;
  int cycle_count;
  int a5_made;
  int kind_seen [4];
  int status_seen [4];
  int filt_marks;

  rs485_pump_frame_recognizer #(
    .DLE_MAX_BYTES(DLE_LIMIT),
    .LOG_MIN_BYTES(LOG_MIN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_kind(frame_kind),
    .frame_status(frame_status),
    .dest_addr(dest_addr),
    .src_addr(src_addr),
    .command_code(command_code),
    .payload_len(payload_len),
    .frame_bytes(frame_bytes),
    .filtered_out(filtered_out),
    .rx_checksum(rx_checksum)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one parser step; returns 1 when the byte closes a frame
  function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r);
    logic [15:0] cks;
    logic [8:0]  fsz;
    logic [7:0]  term;
    logic [1:0]  kind;
    logic        filt;
    logic        is_log;
    r = NO_FRAME;
    case (ph)
      PH_HUNT: begin
        if (b == A5_START) begin
          ph = PH_A5_HDR;
          cnt = 9'd1;
          a5_sum = 16'(A5_START);
          esc = 1'b0;
          hd_dest = '0;
          hd_src = '0;
          hd_cmd = '0;
          hd_len = '0;
          chk_hi = '0;
        end else if (esc && (b == DLE_STX || b == LOG_STX)) begin
          ph = (b == DLE_STX) ? PH_DLE_02 : PH_DLE_90;
          cnt = 9'd2;
          prev_byte = b;
          chk_hi = DLE;
          dle_sum = DLE_SEED;
          esc = 1'b0;
        end else begin
          esc = (b == DLE);
        end
        return 1'b0;
      end
      PH_A5_HDR: begin
        a5_sum = a5_sum + 16'(b);
        case (cnt)
          9'd2: hd_dest = b;
          9'd3: hd_src = b;
          9'd4: hd_cmd = b;
          9'd5: hd_len = b;
          default: ;
        endcase
        cnt = cnt + 9'd1;
        if (cnt >= 9'(A5_HDR_BYTES))
          ph = (hd_len != 8'd0) ? PH_A5_BODY : PH_A5_CK1;
        return 1'b0;
      end
      PH_A5_BODY: begin
        a5_sum = a5_sum + 16'(b);
        cnt = cnt + 9'd1;
        if (cnt >= 9'(A5_HDR_BYTES) + 9'(hd_len))
          ph = PH_A5_CK1;
        return 1'b0;
      end
      PH_A5_CK1: begin
        chk_hi = b;
        cnt = cnt + 9'd1;
        ph = PH_A5_CK2;
        return 1'b0;
      end
      PH_A5_CK2: begin
        cks = {chk_hi, b};
        r.frame_kind   = KIND_A5;
        r.frame_status = (a5_sum == cks) ? ST_OK : ST_BAD_CKS;
        r.dest_addr    = hd_dest;
        r.src_addr     = hd_src;
        r.command_code = hd_cmd;
        r.payload_len  = hd_len;
        r.frame_bytes  = cnt + 9'd1;
        r.filtered_out = (filt_reg != 8'd0) && (hd_dest != filt_reg) && (hd_src != filt_reg);
        r.rx_checksum  = cks;
        ph = PH_HUNT;
        cnt = '0;
        esc = 1'b0;
        return 1'b1;
      end
      PH_DLE_02, PH_DLE_90: begin
        is_log = (ph == PH_DLE_90);
        term = is_log ? LOG_ETX : DLE_ETX;
        kind = is_log ? KIND_LOG : KIND_DLE;
        filt = (filt_reg != 8'd0);
        r.frame_kind = kind;
        r.filtered_out = filt;
        // terminator: DLE then the matching end byte
        if (cnt >= 9'd3 && prev_byte == DLE && b == term) begin
          fsz = cnt + 9'd1;
          r.frame_bytes = fsz;
          if (is_log && fsz < 9'(LOG_MIN)) begin
            r.frame_status = ST_NO_TERM;
          end else begin
            r.frame_status = (dle_sum == chk_hi) ? ST_OK : ST_BAD_CKS;
            r.payload_len  = (fsz >= 9'd5) ? 8'(fsz - 9'd5) : 8'd0;
            r.rx_checksum  = 16'(chk_hi);
          end
          ph = PH_HUNT;
          cnt = '0;
          esc = 1'b0;
          return 1'b1;
        end
        // checksum lags two bytes behind the stream
        if (cnt >= 9'd4)
          dle_sum = dle_sum + chk_hi;
        chk_hi = prev_byte;
        prev_byte = b;
        cnt = cnt + 9'd1;
        if (cnt >= 9'(DLE_LIMIT)) begin
          r.frame_status = ST_NO_TERM;
          r.frame_bytes  = 9'(DLE_LIMIT);
          ph = PH_HUNT;
          cnt = '0;
          esc = 1'b0;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        ph = PH_HUNT;
        cnt = '0;
        esc = 1'b0;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    fail_count++;
    if (fail_count <= 40)
      $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // header address, often the filter value so both marks occur
  function automatic logic [7:0] pick_addr();
    if ($urandom_range(0, 9) < 3) return filt_reg;
    return 8'($urandom);
  endfunction

  // beat monitor: parser model on input beats, checks on result beats
  always @(posedge clk) begin : beat_monitor
    frame_result_t got;
    frame_result_t want;
    frame_result_t pred;
    if (rst) begin
      ph = PH_HUNT;
      cnt = '0;
      esc = 1'b0;
      filt_reg = '0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_in++;
        if (parse_byte(rx_byte, pred))
          expected_frames.push_back(beat_typed ? beat_want : pred);
      end
      if (out_valid && out_ready) begin
        got = {frame_kind, frame_status, dest_addr, src_addr, command_code,
               payload_len, frame_bytes, filtered_out, rx_checksum};
        if (expected_frames.size() == 0) begin
          flag_mismatch("frame result with none expected", got.rx_checksum, 16'h0);
        end else begin
          want = expected_frames.pop_front();
          if (got.frame_kind !== want.frame_kind)
            flag_mismatch("frame_kind", 16'(got.frame_kind), 16'(want.frame_kind));
          if (got.frame_status !== want.frame_status)
            flag_mismatch("frame_status", 16'(got.frame_status), 16'(want.frame_status));
          if (got.dest_addr !== want.dest_addr)
            flag_mismatch("dest_addr", 16'(got.dest_addr), 16'(want.dest_addr));
          if (got.src_addr !== want.src_addr)
            flag_mismatch("src_addr", 16'(got.src_addr), 16'(want.src_addr));
          if (got.command_code !== want.command_code)
            flag_mismatch("command_code", 16'(got.command_code), 16'(want.command_code));
          if (got.payload_len !== want.payload_len)
            flag_mismatch("payload_len", 16'(got.payload_len), 16'(want.payload_len));
          if (got.frame_bytes !== want.frame_bytes)
            flag_mismatch("frame_bytes", 16'(got.frame_bytes), 16'(want.frame_bytes));
          if (got.filtered_out !== want.filtered_out)
            flag_mismatch("filtered_out", 16'(got.filtered_out), 16'(want.filtered_out));
          if (got.rx_checksum !== want.rx_checksum)
            flag_mismatch("rx_checksum", got.rx_checksum, want.rx_checksum);
          kind_seen[want.frame_kind]++;
          status_seen[want.frame_status]++;
          if (want.filtered_out) filt_marks++;
        end
      end
      if (cfg_valid && cfg_ready)
        filt_reg = cfg_data;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: ready stretches broken by random stalls
  initial begin : result_stall
    int hold;
    out_ready = 1'b0;
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (hold - 1) @(negedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  // one byte beat, entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic typed, input frame_result_t want);
    int gap;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    beat_typed <= typed;
    beat_want <= want;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // hold the sender until every summary is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_filter(input logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one random frame, a runaway DLE frame or a bit of line noise
  task automatic send_random_frame();
    logic [7:0]  fr [$];
    logic [15:0] s16;
    logic [7:0]  s8;
    logic [7:0]  v;
    logic        is_log;
    logic        clean;
    int          pick;
    int          n;
    pick = $urandom_range(0, 99);
    sender_burst = ($urandom_range(0, 3) == 0);
    if (pick < 40) begin
      // A5 frame, now and then with the longest payload
      a5_made++;
      n = (a5_made % 25 == 10) ? 255 : $urandom_range(0, 8);
      fr.push_back(A5_START);
      fr.push_back(8'($urandom));
      fr.push_back(pick_addr());
      fr.push_back(pick_addr());
      fr.push_back(8'($urandom));
      fr.push_back(n[7:0]);
      repeat (n) fr.push_back(8'($urandom));
      s16 = '0;
      foreach (fr[i]) s16 = s16 + 16'(fr[i]);
      if ($urandom_range(0, 4) == 0) s16 = 16'($urandom);
      fr.push_back(s16[15:8]);
      fr.push_back(s16[7:0]);
    end else if (pick < 80) begin
      // DLE or log frame, mostly with no stray DLE in the body
      is_log = (pick >= 60);
      n = is_log ? $urandom_range(0, 20) : $urandom_range(0, 12);
      clean = ($urandom_range(0, 9) != 0);
      fr.push_back(DLE);
      fr.push_back(is_log ? LOG_STX : DLE_STX);
      s8 = DLE_SEED;
      repeat (n) begin
        v = 8'($urandom);
        if (clean && v == DLE) v = 8'h11;
        fr.push_back(v);
        s8 = s8 + v;
      end
      if ($urandom_range(0, 4) == 0) s8 = 8'($urandom);
      fr.push_back(s8);
      fr.push_back(DLE);
      fr.push_back(is_log ? LOG_ETX : DLE_ETX);
    end else if (pick < 85) begin
      // runaway frame: no terminator before the byte limit
      fr.push_back(DLE);
      fr.push_back(($urandom_range(0, 1) == 0) ? DLE_STX : LOG_STX);
      repeat (DLE_LIMIT - 2) begin
        v = 8'($urandom);
        if (v == DLE) v = 8'h11;
        fr.push_back(v);
      end
    end else begin
      // noise, rarely containing a frame start
      n = $urandom_range(1, 4);
      repeat (n) begin
        v = 8'($urandom);
        if (v == A5_START && $urandom_range(0, 4) != 0) v = 8'h5A;
        fr.push_back(v);
      end
    end
    foreach (fr[i]) send_byte(fr[i], 1'b0, NO_FRAME);
  endtask

  // stimulus
  initial begin : stimulus
    logic [7:0] phase_filter [4];
    int         target;
    int         waited;
    bit         paused;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    beat_typed = 1'b0;
    beat_want = NO_FRAME;
    sender_burst = 1'b0;
    fail_count = 0;
    bytes_in = 0;
    cycle_count = 0;
    a5_made = 0;
    filt_marks = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // hand-built frames; summaries typed in where they end a frame
    dir_rows = '{
      {8'h00, 1'b0, NO_FRAME},
      // escape followed by a non-start byte is dropped
      {DLE, 1'b0, NO_FRAME},
      {8'h55, 1'b0, NO_FRAME},
      // immediate terminator: the second start byte is the checksum
      {DLE, 1'b0, NO_FRAME},
      {DLE_STX, 1'b0, NO_FRAME},
      {DLE, 1'b0, NO_FRAME},
      {DLE_ETX, 1'b1, KIND_DLE, ST_BAD_CKS, 24'h0, 8'd0, 9'd4, 1'b0, 16'h0002},
      // smallest DLE frame with a good checksum
      {DLE, 1'b0, NO_FRAME},
      {DLE_STX, 1'b0, NO_FRAME},
      {DLE_SEED, 1'b0, NO_FRAME},
      {DLE, 1'b0, NO_FRAME},
      {DLE_ETX, 1'b1, KIND_DLE, ST_OK, 24'h0, 8'd0, 9'd5, 1'b0, 16'h0012},
      // log frame far too short
      {DLE, 1'b0, NO_FRAME},
      {LOG_STX, 1'b0, NO_FRAME},
      {DLE, 1'b0, NO_FRAME},
      {LOG_ETX, 1'b1, KIND_LOG, ST_NO_TERM, 24'h0, 8'd0, 9'd4, 1'b0, 16'h0000},
      // pending escape, then an A5 frame with all-ones addresses and command, no payload
      {DLE, 1'b0, NO_FRAME},
      {A5_START, 1'b0, NO_FRAME},
      {8'h00, 1'b0, NO_FRAME},
      {8'hFF, 1'b0, NO_FRAME},
      {8'hFF, 1'b0, NO_FRAME},
      {8'hFF, 1'b0, NO_FRAME},
      {8'h00, 1'b0, NO_FRAME},
      {8'h03, 1'b0, NO_FRAME},
      {8'hA2, 1'b1, KIND_A5, ST_OK, 8'hFF, 8'hFF, 8'hFF, 8'h00, 9'd8, 1'b0, 16'h03A2}
    };
    phase_filter = '{8'hFF, 8'h01, 8'h00, 8'h00};
    phase_filter[2] = 8'($urandom_range(2, 254));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part runs with the filter at its reset value
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_rows[i].rx, dir_rows[i].has_want, dir_rows[i].want);

    // random frames under each filter setting
    foreach (phase_filter[p]) begin
      write_filter(phase_filter[p]);
      target = bytes_in + PHASE_BYTES;
      paused = 1'b0;
      while (bytes_in < target) begin
        send_random_frame();
        if (!paused && bytes_in >= target - PHASE_BYTES / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    // wind down
    in_valid <= 1'b0;
    waited = 0;
    while (expected_frames.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (2 * SETTLE) @(negedge clk);
    if (expected_frames.size() != 0)
      flag_mismatch("frames never emitted", 16'(expected_frames.size()), 16'h0);

    $display("covered %0d bytes and %0d frames: a5 %0d, dle %0d, log %0d, %0d marked by filter",
             bytes_in, kind_seen[0] + kind_seen[1] + kind_seen[2], kind_seen[0],
             kind_seen[1], kind_seen[2], filt_marks);
    $display("checksum ok %0d, checksum bad %0d, runaway or short %0d, mismatches %0d",
             status_seen[0], status_seen[1], status_seen[2], fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rpfr_pkg.sv
rtl/rpfr_parser.sv
rtl/rpfr_out_reg.sv
rtl/rs485_pump_frame_recognizer.sv
tb/tb.sv
